// ===== rtl/core/hlva_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Hough line vote accumulator package
// Shared sizes, operation codes, the sine/cosine table and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package hlva_pkg;

    localparam int ANGLE_HALF_BINS = 64;
    localparam int ANGLE_HALF_SH   = $clog2(ANGLE_HALF_BINS);
    localparam int ANGLE_BINS      = 2 * ANGLE_HALF_BINS;
    localparam int ANGLE_W         = $clog2(ANGLE_BINS);
    localparam int RHO_HALF_BINS   = 512;
    localparam int RHO_BINS        = 2 * RHO_HALF_BINS;
    localparam int RHO_W           = $clog2(RHO_BINS);
    localparam int IMAGE_SIDE      = 256;
    localparam int PIX_W           = $clog2(IMAGE_SIDE);
    localparam int COUNT_WIDTH     = 16;
    localparam int CNT_ADDR_W      = ANGLE_W + RHO_W;
    localparam int CNT_DEPTH       = ANGLE_BINS * RHO_BINS;
    localparam int MAP_ADDR_W      = 2 * PIX_W;
    localparam int MAP_DEPTH       = IMAGE_SIDE * IMAGE_SIDE;
    localparam int TOTAL_W         = 16;
    localparam int GRAD_W          = 12;
    localparam int RANGE_W         = 11;
    localparam int WIN_W           = GRAD_W + 1;
    localparam int T_W             = WIN_W - 4;
    localparam int SC_W            = 16;
    localparam int PROD_W          = PIX_W + 1 + SC_W;
    localparam int SUM_W           = PROD_W + 1;
    localparam int RND_W           = SUM_W - 14;

    localparam logic [RANGE_W-1:0] RANGE_RESET = 11'd160;

    localparam logic [1:0] OP_VOTE   = 2'd0;
    localparam logic [1:0] OP_UNVOTE = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef logic [2*SC_W-1:0] t_sc_rom [ANGLE_BINS];

    typedef struct packed {
        logic load;
        logic clr_step;
        logic map_rd;
        logic map_upd;
        logic reject;
        logic bin_mul;
        logic bin_addr;
        logic bin_rd;
        logic bin_wr;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] in_op;
        logic [1:0] op;
        logic       map_hit;
        logic       bins_left;
        logic       last_bin;
        logic       clr_last;
    } t_dp_sts;

    function automatic logic [SC_W-1:0] f_q30_to_q14(input longint v);
        longint          w;
        longint unsigned u;
        w = (v < 0) ? 64'sd0 : v;
        u = (longint'(unsigned'(w)) + 64'd32768) >> 16;
        return u[SC_W-1:0];
    endfunction

    // Restoring shift-and-subtract division, used only while building the table.
    function automatic longint unsigned f_udiv(input longint unsigned num,
                                               input longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], num[i]};
            if (r >= den) begin
                r    = r - den;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // Q1.14 sine in the upper half and cosine in the lower half, from an
    // eleven-term integer Taylor series evaluated in Q30.
    function automatic t_sc_rom f_build_rom();
        t_sc_rom           rom;
        longint unsigned   a;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   t;
        longint unsigned   dv;
        longint            s;
        longint            c;
        int                k;
        logic [SC_W-1:0]   sn;
        logic [SC_W-1:0]   cs;
        for (int m = 0; m < ANGLE_BINS; m++) begin
            k  = m - ANGLE_HALF_BINS;
            a  = (k < 0) ? longint'(-k) : longint'(k);
            x  = (a * HALF_PI_Q30) >> ANGLE_HALF_SH;
            x2 = (x * x) >> 30;
            t  = x;
            s  = longint'(x);
            for (int n = 1; n <= 10; n++) begin
                dv = longint'((2 * n) * (2 * n + 1));
                t  = f_udiv((t * x2) >> 30, dv);
                s  = (n % 2 == 1) ? s - longint'(t) : s + longint'(t);
            end
            t = 64'd1 << 30;
            c = longint'(t);
            for (int n = 1; n <= 10; n++) begin
                dv = longint'((2 * n - 1) * (2 * n));
                t  = f_udiv((t * x2) >> 30, dv);
                c  = (n % 2 == 1) ? c - longint'(t) : c + longint'(t);
            end
            sn = f_q30_to_q14(s);
            cs = f_q30_to_q14(c);
            if (k < 0) begin
                sn = -sn;
            end
            rom[m] = {sn, cs};
        end
        return rom;
    endfunction

    localparam t_sc_rom SC_ROM = f_build_rom();

endpackage
`default_nettype wire

// ===== rtl/core/hlva_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Hough line vote accumulator controller
// Sequences clearing, the voted-map check and the per-bin read-modify-write.
// ----------------------------------------------------------------------------
module hlva_ctrl
    import hlva_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    typedef enum logic [3:0] {
        S_CLR_RST,
        S_IDLE,
        S_CLR_OP,
        S_MAP_RD,
        S_MAP_CHK,
        S_BIN_MUL,
        S_BIN_ADDR,
        S_BIN_RD,
        S_BIN_WR,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd       = '0;
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_CLR_RST: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_sts.in_op == OP_CLEAR) begin
                        n_state = S_CLR_OP;
                    end else if (i_sts.in_op == OP_VOTE || i_sts.in_op == OP_UNVOTE) begin
                        n_state = S_MAP_RD;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_CLR_OP: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_DONE;
                end
            end
            S_MAP_RD: begin
                o_cmd.map_rd = 1'b1;
                n_state      = S_MAP_CHK;
            end
            S_MAP_CHK: begin
                if (i_sts.op == OP_UNVOTE && !i_sts.map_hit) begin
                    o_cmd.reject = 1'b1;
                    n_state      = S_DONE;
                end else begin
                    o_cmd.map_upd = 1'b1;
                    n_state       = i_sts.bins_left ? S_BIN_MUL : S_DONE;
                end
            end
            S_BIN_MUL: begin
                o_cmd.bin_mul = 1'b1;
                n_state       = S_BIN_ADDR;
            end
            S_BIN_ADDR: begin
                o_cmd.bin_addr = 1'b1;
                n_state        = S_BIN_RD;
            end
            S_BIN_RD: begin
                o_cmd.bin_rd = 1'b1;
                n_state      = S_BIN_WR;
            end
            S_BIN_WR: begin
                o_cmd.bin_wr = 1'b1;
                n_state      = i_sts.last_bin ? S_DONE : S_BIN_MUL;
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

// ===== rtl/core/hlva_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Hough line vote accumulator datapath
// Holds the count and voted-map memories, the rho arithmetic and the peak.
// ----------------------------------------------------------------------------
module hlva_dp
    import hlva_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire t_dp_cmd                   i_cmd,
    output t_dp_sts                        o_sts,
    input  wire logic [RANGE_W-1:0]        i_angle_range,
    input  wire logic [1:0]                i_operation,
    input  wire logic [PIX_W-1:0]          i_pixel_row,
    input  wire logic [PIX_W-1:0]          i_pixel_col,
    input  wire logic signed [GRAD_W-1:0]  i_gradient_bin,
    input  wire logic [COUNT_WIDTH-1:0]    i_threshold,
    output logic                           o_found,
    output logic signed [ANGLE_W-1:0]      o_peak_angle,
    output logic signed [RHO_W-1:0]        o_peak_rho,
    output logic [COUNT_WIDTH-1:0]         o_peak_votes,
    output logic                           o_accepted,
    output logic [TOTAL_W-1:0]             o_votes_outstanding
);

    logic [COUNT_WIDTH-1:0]     r_counts [CNT_DEPTH];
    logic                       r_voted  [MAP_DEPTH];

    logic [1:0]                 r_op;
    logic [PIX_W-1:0]           r_row;
    logic [PIX_W-1:0]           r_col;
    logic signed [T_W-1:0]      r_t;
    logic signed [T_W-1:0]      r_end;
    logic                       r_map_q;
    logic [TOTAL_W-1:0]         r_total;
    logic [CNT_ADDR_W-1:0]      r_clr;
    logic signed [PROD_W-1:0]   r_ps;
    logic signed [PROD_W-1:0]   r_pc;
    logic [CNT_ADDR_W-1:0]      r_addr;
    logic signed [RHO_W-1:0]    r_rho;
    logic [COUNT_WIDTH-1:0]     r_cnt_q;
    logic [COUNT_WIDTH-1:0]     r_maxval;
    logic                       r_found;
    logic signed [ANGLE_W-1:0]  r_pk_a;
    logic signed [RHO_W-1:0]    r_pk_r;
    logic                       r_accept;

    logic signed [WIN_W-1:0]    win_lo;
    logic signed [WIN_W-1:0]    win_hi;
    logic signed [WIN_W-1:0]    lo_adj;
    logic signed [WIN_W-1:0]    hi_adj;
    logic [ANGLE_W-1:0]         m_idx;
    logic [2*SC_W-1:0]          sc_word;
    logic signed [SUM_W-1:0]    y_sum;
    logic signed [RND_W-1:0]    rho_full;
    logic signed [RHO_W-1:0]    rho_clamp;
    logic [MAP_ADDR_W-1:0]      pix;
    logic [COUNT_WIDTH-1:0]     n_cnt;
    logic signed [T_W-1:0]      t_inc;

    // Window ends, truncated toward zero.
    assign win_lo = WIN_W'(i_gradient_bin) - $signed({2'b00, i_angle_range});
    assign win_hi = WIN_W'(i_gradient_bin) + $signed({2'b00, i_angle_range});
    assign lo_adj = win_lo + $signed({{(WIN_W-4){1'b0}}, {4{win_lo[WIN_W-1]}}});
    assign hi_adj = win_hi + $signed({{(WIN_W-4){1'b0}}, {4{win_hi[WIN_W-1]}}});

    // Wrapped angle index: (t + ANGLE_HALF_BINS) mod ANGLE_BINS.
    assign m_idx   = r_t[ANGLE_W-1:0] ^ {1'b1, {(ANGLE_W-1){1'b0}}};
    assign sc_word = SC_ROM[m_idx];

    assign y_sum    = SUM_W'(r_ps) + SUM_W'(r_pc) + SUM_W'(8192);
    assign rho_full = y_sum[SUM_W-1:14];

    always_comb begin
        if (rho_full < -RND_W'(RHO_HALF_BINS)) begin
            rho_clamp = {1'b1, {(RHO_W-1){1'b0}}};
        end else if (rho_full > RND_W'(RHO_HALF_BINS - 1)) begin
            rho_clamp = {1'b0, {(RHO_W-1){1'b1}}};
        end else begin
            rho_clamp = rho_full[RHO_W-1:0];
        end
    end

    assign pix   = {r_row, r_col};
    assign t_inc = r_t + T_W'(1);

    always_comb begin
        if (r_op == OP_VOTE) begin
            n_cnt = (&r_cnt_q) ? r_cnt_q : r_cnt_q + COUNT_WIDTH'(1);
        end else begin
            n_cnt = (r_cnt_q == '0) ? r_cnt_q : r_cnt_q - COUNT_WIDTH'(1);
        end
    end

    // Count memory: clearing sweep, read and write-back.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            r_counts[r_clr] <= '0;
        end else if (i_cmd.bin_wr) begin
            r_counts[r_addr] <= n_cnt;
        end
        if (i_cmd.bin_rd) begin
            r_cnt_q <= r_counts[r_addr];
        end
    end

    // Voted map: cleared along with the counts, its half of the sweep twice.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            r_voted[r_clr[MAP_ADDR_W-1:0]] <= 1'b0;
        end else if (i_cmd.map_upd) begin
            r_voted[pix] <= (r_op == OP_VOTE);
        end
        if (i_cmd.map_rd) begin
            r_map_q <= r_voted[pix];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr   <= '0;
            r_total <= '0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr <= r_clr + CNT_ADDR_W'(1);
            end
            if (i_cmd.load && i_operation == OP_CLEAR) begin
                r_total <= '0;
            end else if (i_cmd.map_upd) begin
                if (r_op == OP_VOTE) begin
                    if (!r_map_q && !(&r_total)) begin
                        r_total <= r_total + TOTAL_W'(1);
                    end
                end else if (r_total != '0) begin
                    r_total <= r_total - TOTAL_W'(1);
                end
            end
        end
    end

    // Item registers, rho pipeline, peak tracking and result registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_operation;
            r_row    <= i_pixel_row;
            r_col    <= i_pixel_col;
            r_t      <= lo_adj[WIN_W-1:4];
            r_end    <= hi_adj[WIN_W-1:4];
            r_maxval <= i_threshold;
            r_found  <= 1'b0;
            r_pk_a   <= '0;
            r_pk_r   <= '0;
            r_accept <= (i_operation == OP_VOTE || i_operation == OP_UNVOTE ||
                         i_operation == OP_CLEAR);
        end
        if (i_cmd.reject) begin
            r_accept <= 1'b0;
        end
        if (i_cmd.bin_mul) begin
            r_ps <= $signed({1'b0, r_row}) * $signed(sc_word[2*SC_W-1:SC_W]);
            r_pc <= $signed({1'b0, r_col}) * $signed(sc_word[SC_W-1:0]);
        end
        if (i_cmd.bin_addr) begin
            r_rho  <= rho_clamp;
            r_addr <= {m_idx, rho_clamp[RHO_W-1:0] ^ {1'b1, {(RHO_W-1){1'b0}}}};
        end
        if (i_cmd.bin_wr) begin
            r_t <= t_inc;
            if (r_op == OP_VOTE && n_cnt > r_maxval) begin
                r_maxval <= n_cnt;
                r_found  <= 1'b1;
                r_pk_a   <= r_t[ANGLE_W-1:0];
                r_pk_r   <= r_rho;
            end
        end
        if (i_cmd.out_load) begin
            o_found             <= r_found;
            o_peak_angle        <= r_found ? r_pk_a : '0;
            o_peak_rho          <= r_found ? r_pk_r : '0;
            o_peak_votes        <= r_found ? r_maxval : '0;
            o_accepted          <= r_accept;
            o_votes_outstanding <= r_total;
        end
    end

    assign o_sts.in_op     = i_operation;
    assign o_sts.op        = r_op;
    assign o_sts.map_hit   = r_map_q;
    assign o_sts.bins_left = (r_t < r_end);
    assign o_sts.last_bin  = (t_inc == r_end);
    assign o_sts.clr_last  = &r_clr;

endmodule
`default_nettype wire

// ===== rtl/core/hough_line_vote_accumulator.sv =====
`default_nettype none
// A vote or unvote passes from acceptance through the voted-map read and check and, for
// each angle bin in the window, one multiply, one rho round, one count-memory read and one
// write-back, to its result word; a rejected unvote skips the bins. A clear sweeps both
// memories. Throughput: one item at a time; a new word is taken while the previous result
// waits. Reset is synchronous, active low; after it a clearing pass over the count memory
// and voted map runs before the first input word is accepted.
// ----------------------------------------------------------------------------
// Hough line vote accumulator
// Votes and unvotes edge pixels into an (angle, rho) count store and reports the peak.
// ----------------------------------------------------------------------------
module hough_line_vote_accumulator
    import hlva_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // Configuration write channel: the angle window half width.
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [RANGE_W-1:0]        i_cfg_data,
    // Input word channel.
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic [1:0]                i_operation,
    input  wire logic [PIX_W-1:0]          i_pixel_row,
    input  wire logic [PIX_W-1:0]          i_pixel_col,
    input  wire logic signed [GRAD_W-1:0]  i_gradient_bin,
    input  wire logic [COUNT_WIDTH-1:0]    i_threshold,
    // Result word channel.
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output logic                           o_found,
    output logic signed [ANGLE_W-1:0]      o_peak_angle,
    output logic signed [RHO_W-1:0]        o_peak_rho,
    output logic [COUNT_WIDTH-1:0]         o_peak_votes,
    output logic                           o_accepted,
    output logic [TOTAL_W-1:0]             o_votes_outstanding
);

    t_dp_cmd              cmd;
    t_dp_sts              sts;
    logic [RANGE_W-1:0]   r_angle_range;

    // The configuration register is always writable; the user must see that it is only
    // written while the block is idle, so no item ever sees it change mid-window.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_range <= RANGE_RESET;
        end else if (i_cfg_valid) begin
            r_angle_range <= i_cfg_data;
        end
    end

    // The controller steps through the clearing sweep, the voted-map check and
    // the per-bin read-modify-write; the datapath owns both memories.
    hlva_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    hlva_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_sts               (sts),
        .i_angle_range       (r_angle_range),
        .i_operation         (i_operation),
        .i_pixel_row         (i_pixel_row),
        .i_pixel_col         (i_pixel_col),
        .i_gradient_bin      (i_gradient_bin),
        .i_threshold         (i_threshold),
        .o_found             (o_found),
        .o_peak_angle        (o_peak_angle),
        .o_peak_rho          (o_peak_rho),
        .o_peak_votes        (o_peak_votes),
        .o_accepted          (o_accepted),
        .o_votes_outstanding (o_votes_outstanding)
    );

endmodule
`default_nettype wire
